// ===== rtl/core/rlsu_pkg.sv =====
// Shared types and constants for the register file logic and shift unit.
// Depends on nothing; every other file of the block but rlsu_ram refers to it.

package rlsu_pkg;

	localparam int DATA_W       = 64;
	localparam int OPC_W        = 4;
	localparam int REG_FIELD_W  = 4;
	localparam int NUM_REGS_DEF = 16;
	localparam int SHAMT_IMM_W  = 8;

	localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

	// Opcodes that carry no operation leave the destination unchanged.
	typedef enum logic [OPC_W-1:0] {
		OP_AND  = 4'd0,
		OP_OR   = 4'd1,
		OP_XOR  = 4'd2,
		OP_SHL  = 4'd3,
		OP_SHR  = 4'd4,
		OP_NOT  = 4'd5,
		OP_ANDI = 4'd6,
		OP_XORI = 4'd7,
		OP_ORI  = 4'd8,
		OP_SHLI = 4'd9,
		OP_SHRI = 4'd10
	} op_t;

endpackage

// ===== rtl/core/rlsu_inst_if.sv =====
// Instruction channel of the register file logic and shift unit.
// Depends on rlsu_pkg for field widths.

interface rlsu_inst_if;
	logic                                valid;
	logic                                ready;
	logic [rlsu_pkg::OPC_W-1:0]          opcode;
	logic [rlsu_pkg::REG_FIELD_W-1:0]    src_reg;
	logic [rlsu_pkg::REG_FIELD_W-1:0]    dst_reg;
	logic [rlsu_pkg::DATA_W-1:0]         immediate;

	modport source (output valid, output opcode, output src_reg, output dst_reg,
		output immediate, input ready);
	modport sink (input valid, input opcode, input src_reg, input dst_reg,
		input immediate, output ready);
endinterface

// ===== rtl/core/rlsu_result_if.sv =====
// Result channel of the register file logic and shift unit.
// Depends on rlsu_pkg for field widths.

interface rlsu_result_if;
	logic                                valid;
	logic                                ready;
	logic [rlsu_pkg::REG_FIELD_W-1:0]    written_reg;
	logic [rlsu_pkg::DATA_W-1:0]         written_value;

	modport source (output valid, output written_reg, output written_value, input ready);
	modport sink (input valid, input written_reg, input written_value, output ready);
endinterface

// ===== rtl/core/rlsu_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// No dependencies.

module rlsu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/core/rlsu_alu.sv =====
// Logic and shift datapath: combines the destination operand with a source or immediate.
// Depends on rlsu_pkg for the opcode type and widths.

module rlsu_alu (
	input  logic [rlsu_pkg::OPC_W-1:0]  opcode,
	input  logic [rlsu_pkg::DATA_W-1:0] d,
	input  logic [rlsu_pkg::DATA_W-1:0] s,
	input  logic [rlsu_pkg::DATA_W-1:0] immediate,
	output logic [rlsu_pkg::DATA_W-1:0] r
);

	logic [rlsu_pkg::DATA_W-1:0] amt;
	logic                        amt_big;
	logic [rlsu_pkg::DATA_W-1:0] shl_r;
	logic [rlsu_pkg::DATA_W-1:0] shr_r;

	// Register forms shift by the whole source value, immediate forms by its low byte.
	always_comb begin
		if (opcode == rlsu_pkg::OP_SHLI || opcode == rlsu_pkg::OP_SHRI) begin
			amt = {{(rlsu_pkg::DATA_W-rlsu_pkg::SHAMT_IMM_W){1'b0}},
				immediate[rlsu_pkg::SHAMT_IMM_W-1:0]};
		end else begin
			amt = s;
		end
	end

	// Any amount of 64 or more clears the value.
	assign amt_big = |amt[rlsu_pkg::DATA_W-1:6];
	assign shl_r   = amt_big ? '0 : (d << amt[5:0]);
	assign shr_r   = amt_big ? '0 : (d >> amt[5:0]);

	always_comb begin
		unique case (rlsu_pkg::op_t'(opcode))
			rlsu_pkg::OP_AND:  r = d & s;
			rlsu_pkg::OP_OR:   r = d | s;
			rlsu_pkg::OP_XOR:  r = d ^ s;
			rlsu_pkg::OP_SHL:  r = shl_r;
			rlsu_pkg::OP_SHR:  r = shr_r;
			rlsu_pkg::OP_NOT:  r = d ^ rlsu_pkg::ALL_ONES;
			rlsu_pkg::OP_ANDI: r = d & immediate;
			rlsu_pkg::OP_XORI: r = d ^ immediate;
			rlsu_pkg::OP_ORI:  r = d | immediate;
			rlsu_pkg::OP_SHLI: r = shl_r;
			rlsu_pkg::OP_SHRI: r = shr_r;
			default:           r = d;
		endcase
	end

endmodule

// ===== rtl/core/regfile_logic_shift_unit.sv =====
// Top level of the register file logic and shift unit.
// Depends on rlsu_pkg, rlsu_inst_if, rlsu_result_if, rlsu_ram and rlsu_alu.
//
// Usage:
// The block holds NUM_REGS general registers of 64 bits. Each item on the inst
// channel is one decoded logic or shift instruction; it reads the destination
// register (and the source register for register forms), computes the new value
// and writes it back. Exactly one item leaves on the result channel for every
// instruction, carrying the destination index and its new value, in order.
// An accepted instruction reads its registers at the accepting edge into the compute
// stage, then computes and writes back as it moves into the result register, which
// drives the result channel.
// Throughput: one instruction per cycle while result.ready stays high. The register
// file read is registered, so a value written by the instruction in the compute stage
// is forwarded to the instruction being read at the same edge; back-to-back dependent
// instructions therefore run without bubbles.
// Reset: arst_n clears all pipeline valid flags and the per-register valid bits,
// so every register reads as zero until first written; no clearing pass is needed.
// Stall: when the result receiver holds ready low, the result register keeps its
// item, the compute stage holds its instruction, and inst.ready is low while the
// compute stage is occupied and blocked; no item is lost or repeated.

module regfile_logic_shift_unit #(
	parameter int NUM_REGS = rlsu_pkg::NUM_REGS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rlsu_inst_if.sink     inst,
	rlsu_result_if.source result
);

	localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	// Reduce a register field modulo NUM_REGS by repeated subtraction on a narrow value.
	function automatic logic [IDX_W-1:0] reg_index(input logic [rlsu_pkg::REG_FIELD_W-1:0] f);
		logic [rlsu_pkg::REG_FIELD_W:0] v;
		v = {1'b0, f};
		for (int k = 0; k < 8; k++) begin
			if (v >= (rlsu_pkg::REG_FIELD_W+1)'(NUM_REGS)) begin
				v = v - (rlsu_pkg::REG_FIELD_W+1)'(NUM_REGS);
			end
		end
		return v[IDX_W-1:0];
	endfunction

	logic [IDX_W-1:0] src_idx;
	logic [IDX_W-1:0] dst_idx;
	logic             accept;
	logic             s1_adv;

	// Compute stage (s1) holds the instruction whose operands are being read out.
	logic                                s1_valid_q;
	logic [rlsu_pkg::OPC_W-1:0]          opcode_s1;
	logic [IDX_W-1:0]                    dst_s1;
	logic [rlsu_pkg::DATA_W-1:0]         imm_s1;
	logic                                hit_d_s1;
	logic                                hit_s_s1;
	logic                                vld_d_s1;
	logic                                vld_s_s1;
	logic [rlsu_pkg::DATA_W-1:0]         fwd_s1;
	logic [rlsu_pkg::DATA_W-1:0]         ram_d;
	logic [rlsu_pkg::DATA_W-1:0]         ram_s;
	logic [rlsu_pkg::DATA_W-1:0]         op_d;
	logic [rlsu_pkg::DATA_W-1:0]         op_s;
	logic [rlsu_pkg::DATA_W-1:0]         alu_r;

	// A register that was never written since reset reads as zero.
	logic [NUM_REGS-1:0]                 valid_q;

	// Result register.
	logic                                out_valid_q;
	logic [rlsu_pkg::REG_FIELD_W-1:0]    written_reg_q;
	logic [rlsu_pkg::DATA_W-1:0]         written_value_q;

	assign src_idx = reg_index(inst.src_reg);
	assign dst_idx = reg_index(inst.dst_reg);

	assign s1_adv     = s1_valid_q && (!out_valid_q || result.ready);
	assign inst.ready = !s1_valid_q || s1_adv;
	assign accept     = inst.valid && inst.ready;

	rlsu_ram #(
		.WIDTH(rlsu_pkg::DATA_W),
		.DEPTH(NUM_REGS)
	) u_regs (
		.clk     (clk),
		.we      (s1_adv),
		.waddr   (dst_s1),
		.wdata   (alu_r),
		.re      (accept),
		.raddr_a (dst_idx),
		.raddr_b (src_idx),
		.rdata_a (ram_d),
		.rdata_b (ram_s)
	);

	// Operand selection: forwarded result, stored value, or zero for a fresh register.
	always_comb begin
		if (hit_d_s1) begin
			op_d = fwd_s1;
		end else if (vld_d_s1) begin
			op_d = ram_d;
		end else begin
			op_d = '0;
		end
		if (hit_s_s1) begin
			op_s = fwd_s1;
		end else if (vld_s_s1) begin
			op_s = ram_s;
		end else begin
			op_s = '0;
		end
	end

	rlsu_alu u_alu (
		.opcode    (opcode_s1),
		.d         (op_d),
		.s         (op_s),
		.immediate (imm_s1),
		.r         (alu_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q     <= 1'b1;
				valid_q[dst_s1] <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the compute stage. The write of the instruction leaving
	// s1 at this edge is not yet in the RAM read data, so it is forwarded.
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= inst.opcode;
			dst_s1    <= dst_idx;
			imm_s1    <= inst.immediate;
			hit_d_s1  <= s1_adv && (dst_idx == dst_s1);
			hit_s_s1  <= s1_adv && (src_idx == dst_s1);
			vld_d_s1  <= valid_q[dst_idx];
			vld_s_s1  <= valid_q[src_idx];
			fwd_s1    <= alu_r;
		end
		if (s1_adv) begin
			written_reg_q   <= rlsu_pkg::REG_FIELD_W'(dst_s1);
			written_value_q <= alu_r;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.written_reg   = written_reg_q;
	assign result.written_value = written_value_q;

	// The input side only stalls when the compute stage is blocked by a held result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!inst.ready |-> (s1_valid_q && out_valid_q && !result.ready))
		else $error("inst.ready low without a blocked compute stage");

	// Every instruction leaving the compute stage produces a result item.
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid_q)
		else $error("compute stage advanced without a result item");

	// A written register is marked valid from then on.
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> valid_q[$past(dst_s1)])
		else $error("written register not marked valid");

endmodule

// ===== dv/rlsu_tb_pkg.sv =====
`timescale 1ns / 100ps
// Writeback predictor and scoreboard for the register file logic and shift unit testbench.
// Depends on rlsu_pkg for widths, opcodes and the default register count.

package rlsu_tb_pkg;

	import rlsu_pkg::*;

	localparam int TB_NUM_REGS = NUM_REGS_DEF;

	// Opcodes above the last defined one leave the destination untouched.
	localparam logic [OPC_W-1:0] OPC_UNUSED_LO = OPC_W'(int'(OP_SHRI) + 1);
	localparam logic [OPC_W-1:0] OPC_UNUSED_HI = {OPC_W{1'b1}};

	typedef struct packed {
		logic [REG_FIELD_W-1:0] idx;
		logic [DATA_W-1:0]      value;
	} writeback_t;

	class regfile_shadow;
		logic [DATA_W-1:0] regs[TB_NUM_REGS];
		writeback_t        expected_wb[$];
		int unsigned       mismatches;

		function new();
			foreach (regs[k])
				regs[k] = '0;
			mismatches = 0;
		endfunction

		// Logical shift; amounts of 64 or more clear the value.
		static function automatic logic [DATA_W-1:0] lshift(logic [DATA_W-1:0] v,
				logic [DATA_W-1:0] amount, bit to_left);
			if (amount >= DATA_W)
				return '0;
			return to_left ? (v << amount[5:0]) : (v >> amount[5:0]);
		endfunction

		// Executes one accepted instruction on the shadow registers and queues
		// the writeback that the block must report for it.
		function void note_instruction(logic [OPC_W-1:0] opcode,
				logic [REG_FIELD_W-1:0] src_field, logic [REG_FIELD_W-1:0] dst_field,
				logic [DATA_W-1:0] imm);
			int unsigned       s_idx;
			int unsigned       d_idx;
			logic [DATA_W-1:0] d_val;
			logic [DATA_W-1:0] s_val;
			logic [DATA_W-1:0] r;
			writeback_t        wb;
			s_idx = src_field % TB_NUM_REGS;
			d_idx = dst_field % TB_NUM_REGS;
			d_val = regs[d_idx];
			s_val = regs[s_idx];
			case (opcode)
				OP_AND:  r = d_val & s_val;
				OP_OR:   r = d_val | s_val;
				OP_XOR:  r = d_val ^ s_val;
				OP_SHL:  r = lshift(d_val, s_val, 1'b1);
				OP_SHR:  r = lshift(d_val, s_val, 1'b0);
				OP_NOT:  r = d_val ^ ALL_ONES;
				OP_ANDI: r = d_val & imm;
				OP_XORI: r = d_val ^ imm;
				OP_ORI:  r = d_val | imm;
				OP_SHLI: r = lshift(d_val, DATA_W'(imm[SHAMT_IMM_W-1:0]), 1'b1);
				OP_SHRI: r = lshift(d_val, DATA_W'(imm[SHAMT_IMM_W-1:0]), 1'b0);
				default: r = d_val;
			endcase
			regs[d_idx] = r;
			wb.idx      = REG_FIELD_W'(d_idx);
			wb.value    = r;
			expected_wb.push_back(wb);
		endfunction

		function void check_writeback(logic [REG_FIELD_W-1:0] idx, logic [DATA_W-1:0] value);
			writeback_t wb;
			if (expected_wb.size() == 0) begin
				$error("result with no instruction outstanding: written_reg %0d written_value %h",
					idx, value);
				mismatches++;
				return;
			end
			wb = expected_wb.pop_front();
			if (idx !== wb.idx) begin
				$error("written_reg: expected %0d, actual %0d", wb.idx, idx);
				mismatches++;
			end
			if (value !== wb.value) begin
				$error("written_value: expected %h, actual %h", wb.value, value);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return expected_wb.size();
		endfunction
	endclass

endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top-level testbench of regfile_logic_shift_unit: stimulus, result checking and run control.
// Depends on rlsu_pkg, both channel interfaces, the block itself and rlsu_tb_pkg.

module testbench;

	import rlsu_pkg::*;
	import rlsu_tb_pkg::*;

	localparam int RANDOM_ITEMS = 1380;

	logic clk;
	logic arst_n;

	rlsu_inst_if   inst_ch();
	rlsu_result_if res_ch();

	regfile_logic_shift_unit #(
		.NUM_REGS(TB_NUM_REGS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.inst  (inst_ch),
		.result(res_ch)
	);

	regfile_shadow shadow = new();

	// Instructions accepted so far, and what is left of the current sender burst.
	int unsigned issued;
	int unsigned burst_left;

	// Free-running 8 ns clock.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop in case the block hangs; far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Picks a fresh burst length. About one burst in four is long, so that the
	// pipeline also sees extended back-to-back traffic.
	function automatic int unsigned new_burst();
		if ($urandom_range(3) == 0)
			return $urandom_range(40, 120);
		return $urandom_range(1, 12);
	endfunction

	// Drops valid for the given number of cycles; called at a falling edge.
	task automatic hold_off(input int unsigned cycles);
		inst_ch.valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Presents one instruction and waits for its handshake. Entered and left
	// at a falling edge, so valid stays high from one item to the next within
	// a burst and is only lowered when a gap is due.
	task automatic issue(input logic [OPC_W-1:0] opcode, input logic [REG_FIELD_W-1:0] src,
			input logic [REG_FIELD_W-1:0] dst, input logic [DATA_W-1:0] imm);
		inst_ch.valid     = 1'b1;
		inst_ch.opcode    = opcode;
		inst_ch.src_reg   = src;
		inst_ch.dst_reg   = dst;
		inst_ch.immediate = imm;
		do
			@(posedge clk);
		while (inst_ch.ready !== 1'b1);
		shadow.note_instruction(opcode, src, dst, imm);
		issued++;
		@(negedge clk);
		if (burst_left > 1) begin
			burst_left--;
		end else begin
			hold_off($urandom_range(1, 8));
			burst_left = new_burst();
		end
	endtask

	// Lets the block run dry: no new item until every writeback has been seen.
	task automatic drain();
		hold_off(0);
		while (shadow.pending() != 0)
			@(negedge clk);
	endtask

	function automatic logic [DATA_W-1:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// Operand mix: edge values, single bits and dense random patterns.
	function automatic logic [DATA_W-1:0] rand_operand();
		case ($urandom_range(5))
			0:       return '0;
			1:       return ALL_ONES;
			2:       return DATA_W'(1) << $urandom_range(DATA_W - 1);
			default: return rand_word();
		endcase
	endfunction

	// Shift immediate: garbage in the upper bits, an amount in the low byte that mostly
	// lies between 0 and 72, across the 64 boundary, but sometimes covers the full byte.
	function automatic logic [DATA_W-1:0] rand_shift_imm();
		logic [DATA_W-1:0] v;
		v = rand_word();
		if ($urandom_range(3) == 0)
			v[SHAMT_IMM_W-1:0] = SHAMT_IMM_W'($urandom_range(255));
		else
			v[SHAMT_IMM_W-1:0] = SHAMT_IMM_W'($urandom_range(72));
		return v;
	endfunction

	// Mostly the eleven defined operations, now and then an unused opcode.
	function automatic logic [OPC_W-1:0] rand_opcode();
		if ($urandom_range(15) == 0)
			return OPC_W'($urandom_range(OPC_UNUSED_HI, OPC_UNUSED_LO));
		return OPC_W'($urandom_range(OP_SHRI, OP_AND));
	endfunction

	// Puts a small shift amount in a register with two instructions, then shifts
	// a register, possibly the same one, by it. Without this the source of a register
	// shift nearly always holds a huge value and the result is just zero.
	task automatic shift_by_register();
		logic [REG_FIELD_W-1:0] amt_reg;
		logic [REG_FIELD_W-1:0] dst;
		logic [DATA_W-1:0]      amt;
		amt_reg = REG_FIELD_W'($urandom_range(TB_NUM_REGS - 1));
		dst     = REG_FIELD_W'($urandom_range(TB_NUM_REGS - 1));
		amt     = DATA_W'($urandom_range(70));
		issue(OP_ANDI, REG_FIELD_W'($urandom()), amt_reg, '0);
		issue(OP_ORI, REG_FIELD_W'($urandom()), amt_reg, amt);
		if (dst != amt_reg && $urandom_range(1))
			issue(OP_ORI, REG_FIELD_W'($urandom()), dst, rand_word());
		issue($urandom_range(1) ? OP_SHL : OP_SHR, amt_reg, dst, rand_word());
	endtask

	task automatic random_instruction();
		logic [OPC_W-1:0] op;
		op = rand_opcode();
		issue(op, REG_FIELD_W'($urandom()), REG_FIELD_W'($urandom()),
			(op == OP_SHLI || op == OP_SHRI) ? rand_shift_imm() : rand_operand());
	endtask

	// Receiver: ready follows runs of random length with short stalls between
	// them; now and then a long run with no stall at all. Results are checked
	// at the rising edge, ready is changed at the falling edge.
	initial begin : receiver
		int unsigned run_left;
		bit          accepting;
		res_ch.ready = 1'b0;
		run_left     = 0;
		accepting    = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (run_left == 0) begin
				accepting = !accepting;
				if (accepting)
					run_left = ($urandom_range(7) == 0) ? 80 : $urandom_range(1, 20);
				else
					run_left = $urandom_range(1, 6);
			end
			run_left--;
			res_ch.ready = accepting;
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
				shadow.check_writeback(res_ch.written_reg, res_ch.written_value);
		end
	end

	// Main sequence: reset, directed corner cases, random traffic, drain, verdict.
	initial begin : stimulus
		int unsigned pick;
		bit          paused;
		arst_n            = 1'b0;
		inst_ch.valid     = 1'b0;
		inst_ch.opcode    = OP_AND;
		inst_ch.src_reg   = '0;
		inst_ch.dst_reg   = '0;
		inst_ch.immediate = '0;
		issued            = 0;
		burst_left        = new_burst();
		paused            = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Registers start at zero, so the first reads must come back clear.
		issue(OP_XOR, 4'd9, 4'd8, '0);
		issue(OP_ORI, 4'd3, 4'd0, ALL_ONES);
		issue(OP_ORI, 4'd0, 4'd15, {(DATA_W/2){2'b10}});
		issue(OP_XORI, 4'd15, 4'd1, {(DATA_W/2){2'b01}});
		// Register forms, reading registers written just before.
		issue(OP_AND, 4'd0, 4'd2, rand_word());
		issue(OP_OR, 4'd15, 4'd2, rand_word());
		issue(OP_XOR, 4'd0, 4'd2, rand_word());
		issue(OP_NOT, 4'd7, 4'd3, ALL_ONES);
		// Shift by register: by zero, by 63, by exactly 64 and by one.
		issue(OP_SHL, 4'd4, 4'd1, '0);
		issue(OP_ORI, 4'd2, 4'd4, 64'd63);
		issue(OP_SHL, 4'd4, 4'd3, '0);
		issue(OP_SHR, 4'd4, 4'd0, '0);
		issue(OP_ORI, 4'd5, 4'd5, 64'd64);
		issue(OP_SHL, 4'd5, 4'd15, '0);
		issue(OP_SHR, 4'd0, 4'd1, '0);
		// Shift immediates: only the low byte counts, the rest is noise.
		issue(OP_NOT, 4'd0, 4'd6, '0);
		issue(OP_SHLI, 4'd15, 4'd6, {{(DATA_W-SHAMT_IMM_W){1'b1}}, 8'd63});
		issue(OP_SHRI, 4'd9, 4'd6, {{(DATA_W-SHAMT_IMM_W){1'b1}}, 8'd1});
		issue(OP_SHRI, 4'd9, 4'd0, 64'd64);
		issue(OP_SHLI, 4'd9, 4'd15, {{(DATA_W-SHAMT_IMM_W){1'b0}}, 8'hFF});
		issue(OP_ANDI, 4'd1, 4'd1, '0);
		issue(OP_ANDI, 4'd1, 4'd4, ALL_ONES);
		// Unused opcodes must leave the destination as it was.
		issue(OPC_UNUSED_LO, 4'd0, 4'd4, ALL_ONES);
		issue(OPC_UNUSED_HI, 4'd15, 4'd0, rand_word());
		drain();

		// Random traffic, with a single full drain around the halfway mark.
		while (issued < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 55)
				random_instruction();
			else if (pick < 75)
				shift_by_register();
			else if (pick < 85)
				repeat ($urandom_range(2, 8))
					issue(OP_NOT, REG_FIELD_W'($urandom()), REG_FIELD_W'($urandom()),
						rand_word());
			else
				issue($urandom_range(1) ? OP_ORI : OP_XORI, REG_FIELD_W'($urandom()),
					REG_FIELD_W'($urandom()), rand_word());
			if (!paused && issued > RANDOM_ITEMS / 2) begin
				drain();
				paused = 1'b1;
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
